[src/quaternion_normalizer_macros.svh]
// Assertion macros shared by the quaternion normalizer checker.
`ifndef QUATERNION_NORMALIZER_MACROS_SVH
`define QUATERNION_NORMALIZER_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define QN_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// Condition that must hold in the cycle after the antecedent.
`define QN_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/qn_pkg.sv]
// Constants and types of the quaternion normalizer.
package qn_pkg;

  localparam int COMP_BITS = 16;
  localparam int FRAC_BITS = 14;
  localparam int OUT_BITS  = 16;
  localparam int N_COMP    = 4;

  localparam int SQ_W      = 2 * COMP_BITS;
  localparam int SUM_W     = SQ_W + 1;
  localparam int QUO_W     = 2 * FRAC_BITS + 3;
  localparam int RT_W      = FRAC_BITS + 2;
  localparam int RT_IN_W   = 2 * RT_W;
  localparam int LANE_LAT  = QUO_W + RT_W;
  localparam int FRONT_LAT = 3;
  localparam int VLD_LEN   = FRONT_LAT + LANE_LAT;

  localparam logic [OUT_BITS-1:0] ONE_Q = OUT_BITS'(2 ** FRAC_BITS);

  // One step of the restoring divider.
  typedef struct packed {
    logic [SUM_W-1:0] rem;
    logic [SUM_W-1:0] sum;
    logic [QUO_W-1:0] quo;
    logic             neg;
  } div_st_t;

  // One step of the digit-by-digit square root.
  typedef struct packed {
    logic [RT_W+1:0]    rem;
    logic [RT_W-1:0]    root;
    logic [RT_IN_W-1:0] rad;
    logic               neg;
  } rt_st_t;

endpackage

[src/qn_lane.sv]
// One component lane: pipelined divide of the scaled square by the sum, then square root.
module qn_lane (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic [qn_pkg::SQ_W-1:0]  sq_i,
  input  logic [qn_pkg::SUM_W-1:0] sum_i,
  input  logic                     neg_i,
  output logic [qn_pkg::RT_W-1:0]  root_o,
  output logic                     neg_o
);
  import qn_pkg::*;

  div_st_t div_q [QUO_W];
  div_st_t div_d [QUO_W];
  rt_st_t  rt_q  [RT_W];
  rt_st_t  rt_d  [RT_W];

  // The dividend is sq << (2F+2); the divider starts from sq >> 1 and shifts in sq[0], then zeros.
  for (genvar k = 0; k < QUO_W; k++) begin : g_div
    div_st_t         src;
    logic            bit_in;
    logic [SUM_W:0]  shifted;
    logic [SUM_W:0]  diff;
    logic            ge;

    if (k == 0) begin : g_first
      assign src.rem = SUM_W'(sq_i >> 1);
      assign src.sum = sum_i;
      assign src.quo = '0;
      assign src.neg = neg_i;
      assign bit_in  = sq_i[0];
    end else begin : g_next
      assign src    = div_q[k-1];
      assign bit_in = 1'b0;
    end

    assign shifted = {src.rem, bit_in};
    assign diff    = shifted - {1'b0, src.sum};
    assign ge      = shifted >= {1'b0, src.sum};

    always_comb begin
      div_d[k].rem = ge ? diff[SUM_W-1:0] : shifted[SUM_W-1:0];
      div_d[k].sum = src.sum;
      div_d[k].quo = {src.quo[QUO_W-2:0], ge};
      div_d[k].neg = src.neg;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        div_q[k] <= div_d[k];
      end
    end
  end

  // Integer square root, two radicand bits per stage.
  for (genvar j = 0; j < RT_W; j++) begin : g_rt
    rt_st_t          src;
    logic [RT_W+3:0] acc;
    logic [RT_W+3:0] trial;
    logic [RT_W+3:0] diff;
    logic            ge;

    if (j == 0) begin : g_first
      assign src.rem  = '0;
      assign src.root = '0;
      assign src.rad  = RT_IN_W'(div_q[QUO_W-1].quo);
      assign src.neg  = div_q[QUO_W-1].neg;
    end else begin : g_next
      assign src = rt_q[j-1];
    end

    assign acc   = {src.rem, src.rad[RT_IN_W-1 -: 2]};
    assign trial = {2'b00, src.root, 2'b01};
    assign diff  = acc - trial;
    assign ge    = acc >= trial;

    always_comb begin
      rt_d[j].rem  = ge ? diff[RT_W+1:0] : acc[RT_W+1:0];
      rt_d[j].root = {src.root[RT_W-2:0], ge};
      rt_d[j].rad  = src.rad << 2;
      rt_d[j].neg  = src.neg;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rt_q[j] <= rt_d[j];
      end
    end
  end

  assign root_o = rt_q[RT_W-1].root;
  assign neg_o  = rt_q[RT_W-1].neg;

endmodule

[src/quaternion_normalizer.sv]
// Top level of the quaternion normalizer: unit-length Q2.14 orientation per beat.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+------------------------------------------
//   in      | sink      | valid_i / stall_o  | has_rotation_i, raw_w_i .. raw_z_i
//   out     | source    | valid_o / stall_i  | norm_x_o .. norm_w_o, identity_used_o
//
// One beat enters per cycle while the output is not stalled; each beat passes through
// three front stages for squares and sum, 31 divider stages, 16 root stages and the
// output register. The divider and root chains make up most of the pipeline depth.
// Reset clears all valid bits; payload registers are not reset.
// When the output beat is stalled the whole pipeline holds and stall_o is raised.
module quaternion_normalizer (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               valid_i,
  output logic                               stall_o,
  input  logic                               has_rotation_i,
  input  logic signed [qn_pkg::COMP_BITS-1:0] raw_w_i,
  input  logic signed [qn_pkg::COMP_BITS-1:0] raw_x_i,
  input  logic signed [qn_pkg::COMP_BITS-1:0] raw_y_i,
  input  logic signed [qn_pkg::COMP_BITS-1:0] raw_z_i,
  output logic                               valid_o,
  input  logic                               stall_i,
  output logic signed [qn_pkg::OUT_BITS-1:0] norm_x_o,
  output logic signed [qn_pkg::OUT_BITS-1:0] norm_y_o,
  output logic signed [qn_pkg::OUT_BITS-1:0] norm_z_o,
  output logic signed [qn_pkg::OUT_BITS-1:0] norm_w_o,
  output logic                               identity_used_o
);
  import qn_pkg::*;

  logic                 adv;
  logic [COMP_BITS-1:0] raw      [N_COMP];
  logic [COMP_BITS-1:0] mag_a_q  [N_COMP];
  logic [N_COMP-1:0]    neg_a_q, neg_b_q, neg_c_q;
  logic                 has_a_q, has_b_q;
  logic [SQ_W-1:0]      sq_b_q   [N_COMP];
  logic [SQ_W-1:0]      sq_c_q   [N_COMP];
  logic [SUM_W-1:0]     sum_d, sum_c_q;
  logic                 ident_c_d;
  logic [VLD_LEN-1:0]   vld_q;
  logic [LANE_LAT:0]    ident_q;
  logic [RT_W-1:0]      root     [N_COMP];
  logic [N_COMP-1:0]    neg_l;
  logic [OUT_BITS-1:0]  res_d    [N_COMP];
  logic [OUT_BITS-1:0]  res_q    [N_COMP];
  logic                 out_vld_q, out_ident_q;

  assign adv     = !(out_vld_q && stall_i);
  assign stall_o = !adv;

  // Lane order matches the output: x, y, z, w.
  assign raw[0] = raw_x_i;
  assign raw[1] = raw_y_i;
  assign raw[2] = raw_z_i;
  assign raw[3] = raw_w_i;

  always_comb begin
    sum_d = '0;
    for (int i = 0; i < N_COMP; i++) begin
      sum_d = sum_d + SUM_W'(sq_b_q[i]);
    end
    ident_c_d = !has_b_q || (sum_d == '0);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < N_COMP; i++) begin
        neg_a_q[i] <= raw[i][COMP_BITS-1];
        mag_a_q[i] <= raw[i][COMP_BITS-1] ? (~raw[i] + 1'b1) : raw[i];
        sq_b_q[i]  <= mag_a_q[i] * mag_a_q[i];
        sq_c_q[i]  <= sq_b_q[i];
        res_q[i]   <= res_d[i];
      end
      has_a_q     <= has_rotation_i;
      has_b_q     <= has_a_q;
      neg_b_q     <= neg_a_q;
      neg_c_q     <= neg_b_q;
      sum_c_q     <= sum_d;
      ident_q     <= {ident_q[LANE_LAT-1:0], ident_c_d};
      out_ident_q <= ident_q[LANE_LAT];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      vld_q     <= {vld_q[VLD_LEN-2:0], valid_i};
      out_vld_q <= vld_q[VLD_LEN-1];
    end
  end

  for (genvar i = 0; i < N_COMP; i++) begin : g_lane
    logic [RT_W:0]       q_ext;
    logic [OUT_BITS-1:0] qv;

    qn_lane u_lane (
      .clk_i  (clk_i),
      .en_i   (adv),
      .sq_i   (sq_c_q[i]),
      .sum_i  (sum_c_q),
      .neg_i  (neg_c_q[i]),
      .root_o (root[i]),
      .neg_o  (neg_l[i])
    );

    // Rounded magnitude is (isqrt + 1) / 2.
    assign q_ext = {1'b0, root[i]} + 1'b1;
    assign qv    = OUT_BITS'(q_ext[RT_W:1]);

    always_comb begin
      if (ident_q[LANE_LAT]) begin
        res_d[i] = (i == N_COMP - 1) ? ONE_Q : '0;
      end else begin
        res_d[i] = neg_l[i] ? (~qv + 1'b1) : qv;
      end
    end
  end

  assign valid_o         = out_vld_q;
  assign identity_used_o = out_ident_q;
  assign norm_x_o        = res_q[0];
  assign norm_y_o        = res_q[1];
  assign norm_z_o        = res_q[2];
  assign norm_w_o        = res_q[3];

endmodule

[src/qn_checker.sv]
// Port-level checker for the quaternion normalizer and its bind.
`include "quaternion_normalizer_macros.svh"

module qn_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               stall_o,
  input logic                               valid_o,
  input logic                               stall_i,
  input logic signed [qn_pkg::OUT_BITS-1:0] norm_x_o,
  input logic signed [qn_pkg::OUT_BITS-1:0] norm_y_o,
  input logic signed [qn_pkg::OUT_BITS-1:0] norm_z_o,
  input logic signed [qn_pkg::OUT_BITS-1:0] norm_w_o,
  input logic                               identity_used_o
);
  import qn_pkg::*;

  logic signed [OUT_BITS:0]   lim;
  logic        [4*OUT_BITS:0] out_pay;
  logic                       id_ok;
  logic                       in_range;

  assign lim     = (OUT_BITS+1)'(2 ** FRAC_BITS);
  assign out_pay = {norm_x_o, norm_y_o, norm_z_o, norm_w_o, identity_used_o};
  assign id_ok   = (norm_x_o == '0) && (norm_y_o == '0) && (norm_z_o == '0) &&
                   (norm_w_o == lim[OUT_BITS-1:0]);
  assign in_range = (norm_x_o <= lim) && (norm_x_o >= -lim) &&
                    (norm_y_o <= lim) && (norm_y_o >= -lim) &&
                    (norm_z_o <= lim) && (norm_z_o >= -lim) &&
                    (norm_w_o <= lim) && (norm_w_o >= -lim);

  // A stalled output beat keeps its payload.
  `QN_ASSERT_NEXT(a_out_hold, valid_o && stall_i, valid_o && $stable(out_pay), "Stalled output beat changed.")

  // The input side is held back only by a stalled output beat.
  `QN_ASSERT_ALWAYS(a_stall_cause, !stall_o || (valid_o && stall_i), "Input stalled without cause.")

  // A substituted identity reads (0, 0, 0, 1.0).
  `QN_ASSERT_ALWAYS(a_identity, !(valid_o && identity_used_o) || id_ok, "Identity beat has wrong components.")

  // Every unit component lies within plus and minus one.
  `QN_ASSERT_ALWAYS(a_bound, !valid_o || in_range, "Component exceeds unit magnitude.")

endmodule

bind quaternion_normalizer qn_checker u_qn_checker (.*);
